FILE: design/rbr_pkg.sv
// Shared types and constants for the receive byte ring with packet count.
package rbr_pkg;

  // Default ring depth in bytes
  localparam int unsigned CAPACITY_BYTES = 64;

  // Field widths of the transaction payloads
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned LEVEL_W = 7;

  // Request codes
  localparam logic [MODE_W-1:0] MODE_PUT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PKT = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOPKT = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [STAT_W-1:0]  status;
    logic               last;
    logic [LEVEL_W-1:0] packet_length;
    logic [LEVEL_W-1:0] fill_level;
    logic [LEVEL_W-1:0] packets_waiting;
  } result_t;

endpackage

FILE: design/rx_byte_ring_with_packet_count.sv
// Receive byte ring for zero-delimited packets: put, byte pop and packet pop.
// Put: no result; a new transaction may start in the next cycle.
// Empty or no-packet pop: result strobed in the cycle after acceptance, no busy.
// Byte pop: busy one cycle for the RAM read, then the result is strobed from the result register.
// Packet pop of n bytes: n results on consecutive cycles after the RAM read, busy while
// streaming; one byte per cycle from the registered RAM read. Reset clears pointers
// and counters at once; stored bytes need no clearing since only written entries are read.
module rx_byte_ring_with_packet_count #(
  parameter int unsigned CAP = rbr_pkg::CAPACITY_BYTES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  rbr_pkg::item_t  item_i,
  output logic            busy,
  output logic            strobe_o,
  output rbr_pkg::result_t result_o
);
  import rbr_pkg::*;

  localparam int unsigned PTR_W = $clog2(CAP);
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(CAP - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAP);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_POP    = 3'b010,
    ST_STREAM = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d, rp_inc, wp_inc;
  logic [CNT_W-1:0] bc_q, bc_d, pc_q, pc_d, len_q, len_d, bc_dec;
  logic             strobe_q, strobe_d;
  result_t          res_q, res_d;
  logic             accept, we;
  logic [PTR_W-1:0] raddr;
  logic [BYTE_W-1:0] rdata;

  assign accept = start && (state_q == ST_IDLE);
  assign rp_inc = (rp_q == PTR_MAX) ? '0 : rp_q + 1'b1;
  assign wp_inc = (wp_q == PTR_MAX) ? '0 : wp_q + 1'b1;
  assign bc_dec = bc_q - 1'b1;

  // Read ahead at the next pointer while streaming
  assign raddr = (state_q == ST_STREAM) ? rp_inc : rp_q;
  assign we    = accept && (item_i.mode == MODE_PUT);

  rbr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(CAP)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wp_q),
    .wdata_i(item_i.data_byte),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Sequence requests and build results
  always_comb begin
    state_d  = state_q;
    rp_d     = rp_q;
    wp_d     = wp_q;
    bc_d     = bc_q;
    pc_d     = pc_q;
    len_d    = len_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    res_d.out_byte      = '0;
    res_d.status        = STAT_OK;
    res_d.last          = 1'b1;
    res_d.packet_length = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.mode)
            MODE_PUT: begin
              if ((item_i.data_byte == '0) && (pc_q != CNT_MAX)) begin
                pc_d = pc_q + 1'b1;
              end
              wp_d = wp_inc;
              if (bc_q == CNT_MAX) begin
                rp_d = rp_inc;
              end else begin
                bc_d = bc_q + 1'b1;
              end
            end
            MODE_POP: begin
              if (bc_q == '0) begin
                strobe_d     = 1'b1;
                res_d.status = STAT_EMPTY;
              end else begin
                state_d = ST_POP;
              end
            end
            MODE_PKT: begin
              if (pc_q == '0) begin
                strobe_d     = 1'b1;
                res_d.status = STAT_NOPKT;
              end else begin
                pc_d = pc_q - 1'b1;
                if (bc_q == '0) begin
                  strobe_d     = 1'b1;
                  res_d.status = STAT_EMPTY;
                end else begin
                  len_d   = '0;
                  state_d = ST_STREAM;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        strobe_d       = 1'b1;
        res_d.out_byte = rdata;
        rp_d           = rp_inc;
        bc_d           = bc_dec;
        state_d        = ST_IDLE;
      end
      ST_STREAM: begin
        strobe_d = 1'b1;
        rp_d     = rp_inc;
        bc_d     = bc_dec;
        if (rdata == '0) begin
          res_d.packet_length = LEVEL_W'(len_q);
          state_d             = ST_IDLE;
        end else if (bc_dec == '0) begin
          res_d.out_byte      = rdata;
          res_d.status        = STAT_EMPTY;
          res_d.packet_length = LEVEL_W'(len_q + 1'b1);
          state_d             = ST_IDLE;
        end else begin
          res_d.out_byte = rdata;
          res_d.last     = 1'b0;
          len_d          = len_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    res_d.fill_level      = LEVEL_W'(bc_d);
    res_d.packets_waiting = LEVEL_W'(pc_d);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rp_q     <= '0;
      wp_q     <= '0;
      bc_q     <= '0;
      pc_q     <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rp_q     <= rp_d;
      wp_q     <= wp_d;
      bc_q     <= bc_d;
      pc_q     <= pc_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    res_q <= res_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign result_o = res_q;

endmodule

FILE: design/rbr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/rbr_checker.sv
// Port-level checks for the receive byte ring, bound to the top level.
module rbr_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input rbr_pkg::item_t   item_i,
  input logic             busy,
  input logic             strobe_o,
  input rbr_pkg::result_t result_o
);
  import rbr_pkg::*;

  // Packet stream continues without gaps until its final transaction
  a_stream_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !result_o.last |=> strobe_o)
    else $error("packet stream broke before its final result");

  // A non-final result only occurs while the block is busy
  a_stream_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !result_o.last |-> busy)
    else $error("non-final result while idle");

  // Non-final results are ok and leave bytes in the queue
  a_stream_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !result_o.last |->
      (result_o.status == STAT_OK) && (result_o.fill_level != '0))
    else $error("non-final result with bad status or empty queue");

  // No-packet result only with zero packets counted, and always final
  a_nopkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (result_o.status == STAT_NOPKT) |->
      result_o.last && (result_o.packets_waiting == '0))
    else $error("no-packet result inconsistent");

  // A put causes no result
  a_put_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (item_i.mode == MODE_PUT) |=> !strobe_o)
    else $error("result after a put");

endmodule

bind rx_byte_ring_with_packet_count rbr_checker u_rbr_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .item_i  (item_i),
  .busy    (busy),
  .strobe_o(strobe_o),
  .result_o(result_o)
);

FILE: tb/sv/rx_byte_ring_with_packet_count_tb.sv
// Self-checking testbench for the receive byte ring with packet count.
module rx_byte_ring_with_packet_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbr_pkg::*;

  localparam int CAP         = CAPACITY_BYTES;
  localparam int MAX_IDLE    = 16;   // longest run of sender idle cycles
  localparam int QUIET_LIMIT = 400;  // cycles without an accepted transaction or a result before giving up
  localparam int TAIL_CYCLES = 10;   // settle time after the last expected result
  localparam int PHASE_ITEMS = 72;
  localparam int PRINT_CAP   = 30;

  typedef struct {
    item_t it;
    bit    drain;  // hold this item until every expected result has come
  } pending_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  item_t   item_i = '0;
  logic    busy;
  logic    strobe_o;
  result_t result_o;

  rx_byte_ring_with_packet_count DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item_i),
    .busy     (busy),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

  // Shadow copy of the ring
  logic [7:0] ring_mem [CAP];
  int         ring_rd;
  int         ring_wr;
  int         ring_fill;
  int         ring_pkts;

  pending_t pending_items[$];
  result_t  expected_results[$];

  int  idle_pct = 0;
  int  idle_run = 0;
  bit  took = 1'b0;
  bit  drain_next = 1'b0;
  int  quiet_cycles = 0;
  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_pkt_pops = 0;
  int  errors = 0;

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int ring_next(int p);
    return (p == CAP - 1) ? 0 : p + 1;
  endfunction

  // Append one expectation, tagged with the shadow levels after it
  function automatic void expect_result(logic [7:0] b, logic [1:0] st, logic lst, int len);
    result_t r;
    r.out_byte        = b;
    r.status          = st;
    r.last            = lst;
    r.packet_length   = len[6:0];
    r.fill_level      = ring_fill[6:0];
    r.packets_waiting = ring_pkts[6:0];
    expected_results.push_back(r);
  endfunction

  function automatic logic [7:0] ring_take();
    logic [7:0] b;
    b = ring_mem[ring_rd];
    ring_rd = ring_next(ring_rd);
    ring_fill--;
    return b;
  endfunction

  // Advance the shadow ring by one transaction and queue its results
  function automatic void ring_apply(item_t it);
    logic [7:0] b;
    int k;
    bit done;
    case (it.mode)
      MODE_PUT: begin
        if (it.data_byte == 8'h00 && ring_pkts < CAP) ring_pkts++;
        ring_mem[ring_wr] = it.data_byte;
        ring_wr = ring_next(ring_wr);
        if (ring_fill >= CAP) ring_rd = ring_next(ring_rd);
        else ring_fill++;
      end
      MODE_POP: begin
        if (ring_fill == 0) expect_result(8'h00, STAT_EMPTY, 1'b1, 0);
        else begin
          b = ring_take();
          expect_result(b, STAT_OK, 1'b1, 0);
        end
      end
      MODE_PKT: begin
        n_pkt_pops++;
        if (ring_pkts == 0) expect_result(8'h00, STAT_NOPKT, 1'b1, 0);
        else begin
          ring_pkts--;
          if (ring_fill == 0) expect_result(8'h00, STAT_EMPTY, 1'b1, 0);
          else begin
            k = 0;
            done = 1'b0;
            while (!done && k < CAP) begin
              b = ring_take();
              if (b == 8'h00) begin
                expect_result(8'h00, STAT_OK, 1'b1, k);
                done = 1'b1;
              end else if (ring_fill == 0) begin
                expect_result(b, STAT_EMPTY, 1'b1, k + 1);
                done = 1'b1;
              end else begin
                expect_result(b, STAT_OK, 1'b0, 0);
                k++;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (errors < PRINT_CAP)
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void queue_item(logic [1:0] m, logic [7:0] d);
    pending_t p;
    p.it.mode      = m;
    p.it.data_byte = d;
    p.drain        = drain_next;
    drain_next     = 1'b0;
    pending_items.push_back(p);
    n_queued++;
  endfunction

  // Add one random burst; return how many items count as real work
  function automatic int add_burst();
    int sel;
    int len;
    int n;
    logic [1:0] m;
    n = 0;
    sel = $urandom_range(99);
    if ($urandom_range(19) == 0) drain_next = 1'b1;
    if (sel < 45) begin
      // packet, mostly short and mostly delimited, now and then longer than the ring
      len = ($urandom_range(9) == 0) ? $urandom_range(70, 9) : $urandom_range(8, 0);
      repeat (len) begin
        queue_item(MODE_PUT, 8'($urandom_range(255, 1)));
        n++;
      end
      if ($urandom_range(9) != 0) begin
        queue_item(MODE_PUT, 8'h00);
        n++;
      end
      if ($urandom_range(9) < 7) begin
        queue_item(MODE_PKT, 8'($urandom_range(255)));
        n++;
      end
    end else if (sel < 62) begin
      repeat ($urandom_range(2, 1)) begin
        queue_item(MODE_PKT, 8'($urandom_range(255)));
        n++;
      end
    end else if (sel < 76) begin
      repeat ($urandom_range(3, 1)) begin
        queue_item(MODE_POP, 8'($urandom_range(255)));
        n++;
      end
    end else if (sel < 79) begin
      // flood the ring so the oldest bytes may get dropped
      repeat ($urandom_range(70, 60)) begin
        queue_item(MODE_PUT, ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255)));
        n++;
      end
    end else begin
      m = 2'($urandom_range(3));
      queue_item(m, 8'($urandom_range(255)));
      if (m != 2'd3) n++;
    end
    return n;
  endfunction

  // Driver: present pending transactions at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // hold the current transaction until it is accepted
    end else if (pending_items.size() > 0 &&
                 !(pending_items[0].drain && expected_results.size() > 0) &&
                 (idle_run >= MAX_IDLE || $urandom_range(99) >= idle_pct)) begin
      start  <= 1'b1;
      item_i <= pending_items[0].it;
      void'(pending_items.pop_front());
      idle_run = 0;
    end else begin
      start <= 1'b0;
      if (pending_items.size() > 0) idle_run++;
    end
  end

  // Monitor: check results, then predict for the accepted transaction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      took = start && !busy;
      if (strobe_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, out_byte", int'(result_o.out_byte), 0);
        end else begin
          want = expected_results.pop_front();
          if (result_o.out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(result_o.out_byte), int'(want.out_byte));
          if (result_o.status !== want.status)
            report_mismatch("status", int'(result_o.status), int'(want.status));
          if (result_o.last !== want.last)
            report_mismatch("last", int'(result_o.last), int'(want.last));
          if (result_o.packet_length !== want.packet_length)
            report_mismatch("packet_length", int'(result_o.packet_length),
                            int'(want.packet_length));
          if (result_o.fill_level !== want.fill_level)
            report_mismatch("fill_level", int'(result_o.fill_level),
                            int'(want.fill_level));
          if (result_o.packets_waiting !== want.packets_waiting)
            report_mismatch("packets_waiting", int'(result_o.packets_waiting),
                            int'(want.packets_waiting));
          n_checked++;
        end
      end
      if (took) begin
        ring_apply(item_i);
        n_accepted++;
      end
      quiet_cycles = (took || strobe_o) ? 0 : quiet_cycles + 1;
    end else begin
      took = 1'b0;
    end
  end

  // Watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk_i);
    $display("%0t no transaction for %0d cycles", $realtime, QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int cnt;
    for (int i = 0; i < CAP; i++) ring_mem[i] = 8'h00;
    ring_rd   = 0;
    ring_wr   = 0;
    ring_fill = 0;
    ring_pkts = 0;

    // directed: empty pop, no packet, normal and zero-length packets
    queue_item(MODE_POP, 8'hFF);
    queue_item(MODE_PKT, 8'hFF);
    queue_item(MODE_PUT, 8'hFF);
    queue_item(MODE_PUT, 8'h01);
    queue_item(MODE_PUT, 8'h00);
    queue_item(MODE_PKT, 8'h00);
    queue_item(MODE_PUT, 8'h00);
    queue_item(MODE_PKT, 8'h00);
    queue_item(MODE_PUT, 8'hAA);
    queue_item(MODE_POP, 8'h00);
    // single pop of a delimiter, then a packet pop on an empty ring
    queue_item(MODE_PUT, 8'h00);
    queue_item(MODE_POP, 8'h00);
    queue_item(MODE_PKT, 8'h00);
    // packet pop that drains the ring without reaching a delimiter
    queue_item(MODE_PUT, 8'h00);
    queue_item(MODE_POP, 8'h00);
    queue_item(MODE_PUT, 8'h55);
    queue_item(MODE_PUT, 8'h80);
    queue_item(MODE_PKT, 8'hFF);
    // unused mode is ignored
    queue_item(2'd3, 8'h5A);
    queue_item(MODE_PUT, 8'h7F);
    drain_next = 1'b1;
    queue_item(MODE_POP, 8'h00);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // random phases: no idling, heavy sender idling, no idling, light idling
    for (int ph = 0; ph < 4; ph++) begin
      while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk_i);
      case (ph)
        1:       idle_pct = 68;
        3:       idle_pct = 23;
        default: idle_pct = 0;
      endcase
      drain_next = 1'b1;
      cnt = 0;
      while (cnt < PHASE_ITEMS) cnt += add_burst();
    end

    while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d transactions, %0d results checked, %0d packet pops",
             n_accepted, n_checked, n_pkt_pops);
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
